FILE: sv/rfo_pkg.sv
// Shared types and codes for the ring FIFO with overwrite policy.
`default_nettype none
package rfo_pkg;

	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 5;
	localparam int OFFSET_W   = 4;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GET   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 4'd1;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [VALUE_W-1:0]  push_value;
		logic [OFFSET_W-1:0] offset;
	} rfo_req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic               read_valid;
		logic               push_accepted;
		logic               overwrote;
		logic [COUNT_W-1:0] fill_count;
	} rfo_rsp_t;

endpackage
`default_nettype wire

FILE: sv/ring_fifo_with_overwrite.sv
// Top level of the ring FIFO: pointer control, slot RAM and result stage.
//
//  channel  | signals                         | handshake
//  ---------+---------------------------------+---------------------------
//  request  | start, busy, req                | taken when start && !busy
//  result   | done, rsp                       | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index,| written when valid && ready
//           | cfg_data                        |
//
// Every request's result appears in the cycle after it is taken, from the
// single registered read port of the slot RAM and the registered result flags.
// A new request may be taken every cycle, so busy stays low.
// Reset clears the pointers and the count and loads the default capacity;
// the slot RAM itself is not cleared. The result side cannot stall.
`default_nettype none
module ring_fifo_with_overwrite
	import rfo_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire rfo_req_t              req,
	output logic                       done,
	output rfo_rsp_t                   rsp,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int SUM_W   = ((PTR_W > COUNT_W) ? PTR_W : COUNT_W) + 1;
	localparam int CAP_RST = (16 > DEPTH) ? DEPTH : 16;

	logic [PTR_W-1:0]   oldest_q, next_q;
	logic [COUNT_W-1:0] count_q, cap_q;
	logic               policy_q;

	logic [PTR_W-1:0]   oldest_d, next_d, raddr;
	logic [COUNT_W-1:0] count_d;
	logic               we, re, acc, ovw, rvalid;
	logic [COUNT_W-1:0] cap_wr;
	logic [SUM_W-1:0]   get_sum;
	logic [ELEM_WIDTH-1:0] rdata;

	logic               valid_s1, rvalid_s1, acc_s1, ovw_s1;
	logic [COUNT_W-1:0] count_s1;

	logic               take, full, empty;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
		input logic [COUNT_W-1:0] cap);
		logic [SUM_W-1:0] n;
		n = SUM_W'(p) + SUM_W'(1);
		return (n >= SUM_W'(cap)) ? '0 : PTR_W'(n);
	endfunction

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;
	assign full      = count_q >= cap_q;
	assign empty     = count_q == '0;

	// Indexed read: oldest + offset stays below twice the capacity.
	always_comb begin
		get_sum = SUM_W'(oldest_q) + SUM_W'(req.offset);
		if (get_sum >= SUM_W'(cap_q)) begin
			get_sum = get_sum - SUM_W'(cap_q);
		end
	end

	always_comb begin
		oldest_d = oldest_q;
		next_d   = next_q;
		count_d  = count_q;
		we       = 1'b0;
		re       = 1'b0;
		raddr    = oldest_q;
		acc      = 1'b0;
		ovw      = 1'b0;
		rvalid   = 1'b0;
		case (req.mode)
			MODE_PUSH: begin
				if (!full || policy_q) begin
					we     = take;
					acc    = 1'b1;
					next_d = wrap_inc(next_q, cap_q);
					if (full) begin
						ovw      = 1'b1;
						oldest_d = wrap_inc(oldest_q, cap_q);
					end else begin
						count_d = count_q + COUNT_W'(1);
					end
				end
			end
			MODE_POP: begin
				if (!empty) begin
					re       = take;
					rvalid   = 1'b1;
					oldest_d = wrap_inc(oldest_q, cap_q);
					count_d  = count_q - COUNT_W'(1);
				end
			end
			MODE_PEEK: begin
				if (!empty) begin
					re     = take;
					rvalid = 1'b1;
				end
			end
			MODE_GET: begin
				if ({1'b0, req.offset} < count_q) begin
					re     = take;
					rvalid = 1'b1;
					raddr  = PTR_W'(get_sum);
				end
			end
			MODE_CLEAR: begin
				oldest_d = '0;
				next_d   = '0;
				count_d  = '0;
			end
			default: begin
			end
		endcase
	end

	// Capacity writes use the low COUNT_W bits; zero is clamped to one, above the depth to the depth.
	always_comb begin
		cap_wr = cfg_data[COUNT_W-1:0];
		if (cap_wr == '0) begin
			cap_wr = COUNT_W'(1);
		end else if (32'(cap_wr) > DEPTH) begin
			cap_wr = COUNT_W'(DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			next_q   <= '0;
			count_q  <= '0;
			cap_q    <= COUNT_W'(CAP_RST);
			policy_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (cfg_valid && cfg_ready && cfg_index == CFG_CAPACITY) begin
				cap_q    <= cap_wr;
				oldest_q <= '0;
				next_q   <= '0;
				count_q  <= '0;
			end else if (take) begin
				oldest_q <= oldest_d;
				next_q   <= next_d;
				count_q  <= count_d;
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_POLICY) begin
				policy_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rvalid_s1 <= rvalid;
			acc_s1    <= acc;
			ovw_s1    <= ovw;
			count_s1  <= count_d;
		end
	end

	rfo_ram #(
		.WIDTH(ELEM_WIDTH),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(next_q),
		.wdata(ELEM_WIDTH'(req.push_value)),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign done              = valid_s1;
	assign rsp.read_value    = rvalid_s1 ? VALUE_W'(rdata) : '0;
	assign rsp.read_valid    = rvalid_s1;
	assign rsp.push_accepted = acc_s1;
	assign rsp.overwrote     = ovw_s1;
	assign rsp.fill_count    = count_s1;

	// The write pointer always sits count entries past the read pointer.
	logic [SUM_W-1:0] chk_sum;
	always_comb begin
		chk_sum = SUM_W'(oldest_q) + SUM_W'(count_q);
		if (chk_sum >= SUM_W'(cap_q)) begin
			chk_sum = chk_sum - SUM_W'(cap_q);
		end
	end

	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("entry count exceeds capacity");

	a_ptrs_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SUM_W'(oldest_q) < SUM_W'(cap_q)) && (SUM_W'(next_q) < SUM_W'(cap_q)))
		else $error("pointer outside capacity");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		PTR_W'(chk_sum) == next_q)
		else $error("pointers and count disagree");

	a_overwrite_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.overwrote) |-> (rsp.push_accepted && !rsp.read_valid))
		else $error("overwrite flag without accepted push");

endmodule
`default_nettype wire

FILE: sv/rfo_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module rfo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire
